/* sv/tnt_pkg.sv */
`default_nettype none

package tnt_pkg;

	localparam int VERTEX_INDEX_WIDTH = 16;

	// port widths
	localparam int POS_W = 32;
	localparam int IDX_W = 16;
	localparam int OUT_W = 16;

	localparam logic [IDX_W-1:0] IDX_MASK = (VERTEX_INDEX_WIDTH >= IDX_W) ? {IDX_W{1'b1}} :
		IDX_W'((64'd1 << VERTEX_INDEX_WIDTH) - 64'd1);

	// normaliser datapath
	localparam int D_W     = POS_W + 1;       // exact edge component
	localparam int VEC_W   = 64;              // normaliser input, magnitude below 2^62
	localparam int MAG_W   = 62;
	localparam int SHP_W   = $clog2(MAG_W);
	localparam int SH_W    = 30;              // largest magnitude lands in [2^29, 2^30)
	localparam int L_W     = 62;
	localparam int ROOT_W  = 31;
	localparam int F_HI    = 30;
	localparam int F_LO    = 14;
	localparam int Q30_W   = F_HI + 1;
	localparam int Q14_W   = F_LO + 1;
	localparam int N30_W   = SH_W + F_HI + 1;
	localparam int N14_W   = SH_W + F_LO + 1;
	localparam int ISQ_STEPS = ROOT_W;
	localparam int DIV_STEPS = Q30_W;
	// s1..s5, root seed, root steps, dividend prep, divide steps, sign stage
	localparam int NORM_LAT  = 5 + 1 + ISQ_STEPS + 1 + DIV_STEPS + 1;
	// s1, normaliser A/B, two cross product stages, normaliser C
	localparam int PIPE_LAT  = 1 + NORM_LAT + 2 + NORM_LAT;

	typedef logic [2:0][VEC_W-1:0] wvec_t;

	typedef struct packed {
		logic [L_W-1:0]         rem;
		logic [ROOT_W-1:0]      root;
		logic [2:0][SH_W-1:0]   smag;
		logic [2:0]             neg;
		logic                   nz;
	} isq_t;

	typedef struct packed {
		logic [ROOT_W-1:0]      r;
		logic [2:0][N30_W-1:0]  rem30;
		logic [2:0][Q30_W-1:0]  q30;
		logic [2:0][N14_W-1:0]  rem14;
		logic [2:0][Q14_W-1:0]  q14;
		logic [2:0]             neg;
		logic                   nz;
	} dv_t;

	function automatic logic [SHP_W-1:0] lead_one(input logic [MAG_W-1:0] m);
		logic [SHP_W-1:0] p;
		p = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (m[i]) begin
				p = SHP_W'(i);
			end
		end
		return p;
	endfunction

	// remainder test value for result bit k of the square root
	function automatic logic [L_W:0] isq_trial(input logic [ROOT_W-1:0] root, input int k);
		return ((L_W+1)'(root) << (k + 1)) + ((L_W+1)'(1) << (2 * k));
	endfunction

endpackage

`default_nettype wire

/* sv/tnt_vec_norm.sv */
`default_nettype none

module tnt_vec_norm
	import tnt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire wvec_t                   vec,
	output logic [2:0][Q30_W:0]          q30,
	output logic [2:0][Q14_W:0]          q14,
	output logic                         nz
);

	localparam int TGT = SH_W - 1;

	logic [2:0][MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [2:0]            neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [MAG_W-1:0]      max_s2;
	logic [SHP_W-1:0]      p_s3;
	logic                  nz_s3, nz_s4, nz_s5;
	logic [2:0][SH_W-1:0]  smag_s4, smag_s5;
	logic [2:0][2*SH_W-1:0] sq_s5;

	logic [2:0][MAG_W-1:0] mag_in;
	logic [MAG_W-1:0]      max01;
	logic [2:0][SH_W-1:0]  smag_nx;
	logic [MAG_W-1:0]      sh_tmp;

	isq_t isq_s [ISQ_STEPS+1];
	dv_t  dv_s  [DIV_STEPS+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = vec[i][VEC_W-1] ? MAG_W'(~vec[i] + VEC_W'(1)) : MAG_W'(vec[i]);
		end
		max01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
	end

	always_comb begin
		sh_tmp = '0;
		for (int i = 0; i < 3; i++) begin
			if (p_s3 > SHP_W'(TGT)) begin
				sh_tmp = mag_s3[i] >> (p_s3 - SHP_W'(TGT));
			end else begin
				sh_tmp = mag_s3[i] << (SHP_W'(TGT) - p_s3);
			end
			smag_nx[i] = sh_tmp[SH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][VEC_W-1];
			end

			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			max_s2 <= (max01 > mag_s1[2]) ? max01 : mag_s1[2];

			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			p_s3   <= lead_one(max_s2);
			nz_s3  <= |max_s2;

			smag_s4 <= smag_nx;
			neg_s4  <= neg_s3;
			nz_s4   <= nz_s3;

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= smag_s4[i] * smag_s4[i];
			end
			smag_s5 <= smag_s4;
			neg_s5  <= neg_s4;
			nz_s5   <= nz_s4;

			isq_s[0].rem  <= L_W'(sq_s5[0]) + L_W'(sq_s5[1]) + L_W'(sq_s5[2]);
			isq_s[0].root <= '0;
			isq_s[0].smag <= smag_s5;
			isq_s[0].neg  <= neg_s5;
			isq_s[0].nz   <= nz_s5;
		end
	end

	// square root, one result bit per stage
	for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
		localparam int K = ISQ_STEPS - 1 - j;
		isq_t nx;
		logic [L_W:0] t;
		always_comb begin
			nx = isq_s[j];
			t  = isq_trial(isq_s[j].root, K);
			if ({1'b0, isq_s[j].rem} >= t) begin
				nx.rem  = isq_s[j].rem - L_W'(t);
				nx.root = isq_s[j].root | (ROOT_W'(1) << K);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				isq_s[j+1] <= nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].r   <= isq_s[ISQ_STEPS].root;
			dv_s[0].neg <= isq_s[ISQ_STEPS].neg;
			dv_s[0].nz  <= isq_s[ISQ_STEPS].nz;
			dv_s[0].q30 <= '0;
			dv_s[0].q14 <= '0;
			for (int i = 0; i < 3; i++) begin
				// half the root added for rounding
				dv_s[0].rem30[i] <= N30_W'({isq_s[ISQ_STEPS].smag[i], {F_HI{1'b0}}})
					+ N30_W'(isq_s[ISQ_STEPS].root[ROOT_W-1:1]);
				dv_s[0].rem14[i] <= N14_W'({isq_s[ISQ_STEPS].smag[i], {F_LO{1'b0}}})
					+ N14_W'(isq_s[ISQ_STEPS].root[ROOT_W-1:1]);
			end
		end
	end

	// restoring division; the narrow quotient joins in for its low bits only
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int K = DIV_STEPS - 1 - j;
		dv_t nx;
		always_comb begin
			nx = dv_s[j];
			for (int i = 0; i < 3; i++) begin
				if ({1'b0, dv_s[j].rem30[i]} >= ((N30_W+1)'(dv_s[j].r) << K)) begin
					nx.rem30[i]    = dv_s[j].rem30[i] - (N30_W'(dv_s[j].r) << K);
					nx.q30[i][K]   = 1'b1;
				end
				if (K < Q14_W) begin
					if ({1'b0, dv_s[j].rem14[i]} >= ((N14_W+1)'(dv_s[j].r) << K)) begin
						nx.rem14[i] = dv_s[j].rem14[i] - (N14_W'(dv_s[j].r) << K);
						nx.q14[i]   = dv_s[j].q14[i] | (Q14_W'(1) << K);
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j+1] <= nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				q30[i] <= dv_s[DIV_STEPS].neg[i] ? ~{1'b0, dv_s[DIV_STEPS].q30[i]} + (Q30_W+1)'(1)
					: {1'b0, dv_s[DIV_STEPS].q30[i]};
				q14[i] <= dv_s[DIV_STEPS].neg[i] ? ~{1'b0, dv_s[DIV_STEPS].q14[i]} + (Q14_W+1)'(1)
					: {1'b0, dv_s[DIV_STEPS].q14[i]};
			end
			nz <= dv_s[DIV_STEPS].nz;
		end
	end

endmodule

`default_nettype wire

/* sv/triangle_normal_tangent_unit.sv */
// Triangle face normal and tangent unit.
// Input channel (tri_valid / tri_stall): one triangle per transaction, three
// Q16.16 vertex positions and three vertex indices. Output channel
// (res_valid / res_stall): one result per triangle, in order: unit normal and
// unit first edge in Q1.14, the indices, and a degenerate flag. A zero edge
// or collinear edges give zero vectors with degenerate set.
// Throughput: one triangle per cycle while tri_stall is low. The pipeline is
// normalisers A and B side by side, then normaliser C, each with a 31-stage
// square root and a 31-stage divider, with the cross product stages between them.
// Reset clears all valid bits; data registers, output data among them, are not reset.
// When res_stall holds a result, the pipeline keeps running until the next
// result fills the skid register; only then is tri_stall raised and every
// stage frozen. Nothing is lost or repeated.
`default_nettype none

module triangle_normal_tangent_unit
	import tnt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     tri_valid,
	output logic                          tri_stall,
	input  wire logic signed [POS_W-1:0]  p0_x,
	input  wire logic signed [POS_W-1:0]  p0_y,
	input  wire logic signed [POS_W-1:0]  p0_z,
	input  wire logic signed [POS_W-1:0]  p1_x,
	input  wire logic signed [POS_W-1:0]  p1_y,
	input  wire logic signed [POS_W-1:0]  p1_z,
	input  wire logic signed [POS_W-1:0]  p2_x,
	input  wire logic signed [POS_W-1:0]  p2_y,
	input  wire logic signed [POS_W-1:0]  p2_z,
	input  wire logic [IDX_W-1:0]         vert_a_index,
	input  wire logic [IDX_W-1:0]         vert_b_index,
	input  wire logic [IDX_W-1:0]         vert_c_index,
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output logic signed [OUT_W-1:0]       normal_x,
	output logic signed [OUT_W-1:0]       normal_y,
	output logic signed [OUT_W-1:0]       normal_z,
	output logic signed [OUT_W-1:0]       tangent_x,
	output logic signed [OUT_W-1:0]       tangent_y,
	output logic signed [OUT_W-1:0]       tangent_z,
	output logic [IDX_W-1:0]              out_a_index,
	output logic [IDX_W-1:0]              out_b_index,
	output logic [IDX_W-1:0]              out_c_index,
	output logic                          degenerate
);

	typedef struct packed {
		logic [2:0][IDX_W-1:0] idx;
	} sa_t;

	typedef struct packed {
		logic [2:0][IDX_W-1:0] idx;
		logic [2:0][OUT_W-1:0] tan;
		logic                  ok;
	} sb_t;

	typedef struct packed {
		logic [2:0][OUT_W-1:0] nrm;
		logic [2:0][OUT_W-1:0] tan;
		logic [2:0][IDX_W-1:0] idx;
		logic                  deg;
	} res_t;

	logic en;
	logic [PIPE_LAT-1:0] v_s;

	logic signed [D_W-1:0] d1_s1 [3];
	logic signed [D_W-1:0] d2_s1 [3];
	wvec_t                 va, vb;
	sa_t                   sa_s [NORM_LAT+1];

	logic [2:0][Q30_W:0] ua, ub, uc_unused;
	logic [2:0][Q14_W:0] ta, tb_unused, nc;
	logic                nza, nzb, nzc;

	logic signed [2*(Q30_W+1)-1:0] pr_c1 [6];
	logic [2:0][OUT_W-1:0]         tan_c1;
	logic                          ok_c1;
	sa_t                           sa_c1;
	wvec_t                         cr_c2;
	sb_t                           sb_s [NORM_LAT+1];

	res_t res_nx, res_q, sk_q;
	logic res_valid_q, sk_valid_q;
	logic last_valid;

	assign en        = ~sk_valid_q;
	assign tri_stall = sk_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[PIPE_LAT-2:0], tri_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1[0] <= $signed({p1_x[POS_W-1], p1_x}) - $signed({p0_x[POS_W-1], p0_x});
			d1_s1[1] <= $signed({p1_y[POS_W-1], p1_y}) - $signed({p0_y[POS_W-1], p0_y});
			d1_s1[2] <= $signed({p1_z[POS_W-1], p1_z}) - $signed({p0_z[POS_W-1], p0_z});
			d2_s1[0] <= $signed({p2_x[POS_W-1], p2_x}) - $signed({p0_x[POS_W-1], p0_x});
			d2_s1[1] <= $signed({p2_y[POS_W-1], p2_y}) - $signed({p0_y[POS_W-1], p0_y});
			d2_s1[2] <= $signed({p2_z[POS_W-1], p2_z}) - $signed({p0_z[POS_W-1], p0_z});
			sa_s[0].idx[0] <= vert_a_index & IDX_MASK;
			sa_s[0].idx[1] <= vert_b_index & IDX_MASK;
			sa_s[0].idx[2] <= vert_c_index & IDX_MASK;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = VEC_W'(d1_s1[i]);
			vb[i] = VEC_W'(d2_s1[i]);
		end
	end

	for (genvar j = 0; j < NORM_LAT; j++) begin : g_sa
		always_ff @(posedge clk) begin
			if (en) begin
				sa_s[j+1] <= sa_s[j];
			end
		end
	end

	tnt_vec_norm u_norm_a (
		.clk (clk),
		.en  (en),
		.vec (va),
		.q30 (ua),
		.q14 (ta),
		.nz  (nza)
	);

	tnt_vec_norm u_norm_b (
		.clk (clk),
		.en  (en),
		.vec (vb),
		.q30 (ub),
		.q14 (tb_unused),
		.nz  (nzb)
	);

	// exact cross product of the Q1.30 edges
	always_ff @(posedge clk) begin
		if (en) begin
			pr_c1[0] <= 64'($signed(ua[1])) * 64'($signed(ub[2]));
			pr_c1[1] <= 64'($signed(ua[2])) * 64'($signed(ub[1]));
			pr_c1[2] <= 64'($signed(ua[2])) * 64'($signed(ub[0]));
			pr_c1[3] <= 64'($signed(ua[0])) * 64'($signed(ub[2]));
			pr_c1[4] <= 64'($signed(ua[0])) * 64'($signed(ub[1]));
			pr_c1[5] <= 64'($signed(ua[1])) * 64'($signed(ub[0]));
			for (int i = 0; i < 3; i++) begin
				tan_c1[i] <= ta[i];
			end
			ok_c1 <= nza & nzb;
			sa_c1 <= sa_s[NORM_LAT];

			cr_c2[0] <= VEC_W'(pr_c1[0] - pr_c1[1]);
			cr_c2[1] <= VEC_W'(pr_c1[2] - pr_c1[3]);
			cr_c2[2] <= VEC_W'(pr_c1[4] - pr_c1[5]);
			sb_s[0].idx <= sa_c1.idx;
			sb_s[0].tan <= tan_c1;
			sb_s[0].ok  <= ok_c1;
		end
	end

	for (genvar j = 0; j < NORM_LAT; j++) begin : g_sb
		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[j+1] <= sb_s[j];
			end
		end
	end

	tnt_vec_norm u_norm_c (
		.clk (clk),
		.en  (en),
		.vec (cr_c2),
		.q30 (uc_unused),
		.q14 (nc),
		.nz  (nzc)
	);

	assign last_valid = v_s[PIPE_LAT-1];

	always_comb begin
		res_nx.deg = ~(sb_s[NORM_LAT].ok & nzc);
		res_nx.idx = sb_s[NORM_LAT].idx;
		for (int i = 0; i < 3; i++) begin
			res_nx.nrm[i] = res_nx.deg ? '0 : nc[i];
			res_nx.tan[i] = res_nx.deg ? '0 : sb_s[NORM_LAT].tan[i];
		end
	end

	// output register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			if (sk_valid_q) begin
				res_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end else begin
				res_valid_q <= last_valid;
			end
		end else if (en && last_valid) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || !res_stall) begin
			res_q <= sk_valid_q ? sk_q : res_nx;
		end else if (en) begin
			sk_q <= res_nx;
		end
	end

	assign res_valid   = res_valid_q;
	assign normal_x    = $signed(res_q.nrm[0]);
	assign normal_y    = $signed(res_q.nrm[1]);
	assign normal_z    = $signed(res_q.nrm[2]);
	assign tangent_x   = $signed(res_q.tan[0]);
	assign tangent_y   = $signed(res_q.tan[1]);
	assign tangent_z   = $signed(res_q.tan[2]);
	assign out_a_index = res_q.idx[0];
	assign out_b_index = res_q.idx[1];
	assign out_c_index = res_q.idx[2];
	assign degenerate  = res_q.deg;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none

module tb_top
	import tnt_pkg::*;
;

	localparam int LATENCY = 143;
	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct {
		logic signed [POS_W-1:0] p [9];
		logic [IDX_W-1:0] idx [3];
	} tri_t;

	typedef struct {
		logic signed [OUT_W-1:0] nrm [3];
		logic signed [OUT_W-1:0] tng [3];
		logic [IDX_W-1:0] idx [3];
		logic degen;
	} face_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tri_valid = 1'b0;
	logic tri_stall;
	logic signed [POS_W-1:0] p0_x = '0, p0_y = '0, p0_z = '0;
	logic signed [POS_W-1:0] p1_x = '0, p1_y = '0, p1_z = '0;
	logic signed [POS_W-1:0] p2_x = '0, p2_y = '0, p2_z = '0;
	logic [IDX_W-1:0] vert_a_index = '0, vert_b_index = '0, vert_c_index = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
	logic signed [OUT_W-1:0] tangent_x, tangent_y, tangent_z;
	logic [IDX_W-1:0] out_a_index, out_b_index, out_c_index;
	logic degenerate;

	tri_t pending_tris[$];
	face_t expected_faces[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_tx = 1'b0;
	int tx_gap = 0;
	int rx_gap = 0;
	logic tri_accepted = 1'b0;

	triangle_normal_tangent_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	// scale so the largest magnitude sits in [2^29, 2^30), then divide by the root
	function automatic bit unit_vector(input longint v [3], input int frac, output longint q [3]);
		logic [63:0] mag [3];
		logic [63:0] m, len2, r, c;
		int lead;
		m = 0;
		len2 = 0;
		lead = -1;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
			if (mag[i] > m)
				m = mag[i];
		end
		for (int i = 0; i < 3; i++)
			q[i] = 0;
		if (m == 0)
			return 1'b0;
		for (int i = 0; i < 63; i++)
			if (m[i])
				lead = i;
		for (int i = 0; i < 3; i++) begin
			if (lead > 29)
				mag[i] >>= (lead - 29);
			else
				mag[i] <<= (29 - lead);
			len2 += mag[i] * mag[i];
		end
		r = int_sqrt(len2);
		for (int i = 0; i < 3; i++) begin
			c = ((mag[i] << frac) + (r >> 1)) / r;
			q[i] = (v[i] < 0) ? -longint'(c) : longint'(c);
		end
		return 1'b1;
	endfunction

	function automatic face_t face_of(input tri_t t);
		face_t f;
		longint d1 [3], d2 [3], u1 [3], u2 [3], cr [3], tg [3], nm [3];
		bit ok;
		for (int i = 0; i < 3; i++) begin
			d1[i] = longint'(t.p[3 + i]) - longint'(t.p[i]);
			d2[i] = longint'(t.p[6 + i]) - longint'(t.p[i]);
		end
		ok = unit_vector(d1, 30, u1);
		ok = unit_vector(d2, 30, u2) && ok;
		if (ok) begin
			cr[0] = u1[1] * u2[2] - u1[2] * u2[1];
			cr[1] = u1[2] * u2[0] - u1[0] * u2[2];
			cr[2] = u1[0] * u2[1] - u1[1] * u2[0];
			ok = unit_vector(cr, 14, nm);
		end
		if (ok)
			void'(unit_vector(d1, 14, tg));
		for (int i = 0; i < 3; i++) begin
			f.nrm[i] = ok ? OUT_W'(nm[i]) : '0;
			f.tng[i] = ok ? OUT_W'(tg[i]) : '0;
			f.idx[i] = t.idx[i] & IDX_MASK;
		end
		f.degen = !ok;
		return f;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic logic [31:0] rand_coord(input int mode);
		unique case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
			2: return 32'($signed($urandom_range(0, 200)) - 100);
			default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	task automatic add_tri(input logic [31:0] c [9], input logic [15:0] a, b, cc);
		tri_t t;
		for (int i = 0; i < 9; i++)
			t.p[i] = c[i];
		t.idx[0] = a;
		t.idx[1] = b;
		t.idx[2] = cc;
		pending_tris.push_back(t);
	endtask

	task automatic run_stimulus();
		logic [31:0] c [9];
		int mode, kind;
		// unit right triangle
		c = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
		add_tri(c, 16'h0000, 16'hFFFF, 16'h5555);
		// all points coincide: zero edges
		c = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
		add_tri(c, 16'hFFFF, 16'h0000, 16'hAAAA);
		// p2 equals p0: only the edge from p0 to p2 is zero
		c = '{0, 0, 0, 32'h10000, 0, 0, 0, 0, 0};
		add_tri(c, 16'd1, 16'd2, 16'd3);
		// collinear
		c = '{0, 0, 0, 32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000, 32'h60000};
		add_tri(c, 16'd4, 16'd5, 16'd6);
		// coordinate extremes, edges reach 2^32-1
		c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
		add_tri(c, 16'h8000, 16'h7FFF, 16'h0001);
		c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
		add_tri(c, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// smallest nonzero edges
		c = '{0, 0, 0, 1, 0, 0, 0, 0, 1};
		add_tri(c, 16'd7, 16'd8, 16'd9);
		c = '{1, 1, 1, 0, 0, 1, 1, 0, 0};
		add_tri(c, 16'd10, 16'd11, 16'd12);
		// nearly collinear, large and tiny mixed
		c = '{0, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1, 0};
		add_tri(c, 16'd13, 16'd14, 16'd15);
		c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFEDC_BA98,
			32'h0, 32'h0, 32'h0, 32'h7654_3210};
		add_tri(c, 16'h1234, 16'h4321, 16'hF0F0);
		for (int n = 0; n < 1700; n++) begin
			if (n == 850) begin
				// drain fully before continuing
				do
					@(posedge clk);
				while (pending_tris.size() != 0 || tri_valid);
				hold_tx = 1'b1;
				wait (expected_faces.size() == 0);
				hold_tx = 1'b0;
			end
			mode = $urandom_range(0, 9);
			mode = (mode < 5) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
			for (int i = 0; i < 9; i++)
				c[i] = rand_coord(mode);
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				for (int i = 3; i < 6; i++)
					c[i] = c[i - 3];
			end else if (kind == 1) begin
				for (int i = 0; i < 3; i++)
					c[6 + i] = c[i] + 2 * (c[3 + i] - c[i]);
			end
			add_tri(c, 16'($urandom), 16'($urandom), 16'($urandom));
			while (pending_tris.size() > 64)
				@(posedge clk);
		end
		// every pending transaction handed over and accepted
		do
			@(posedge clk);
		while (pending_tris.size() != 0 || tri_valid);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!tri_valid || tri_accepted) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					tri_valid <= 1'b0;
				end else if (!hold_tx && pending_tris.size() > 0) begin
					tri_t t;
					t = pending_tris.pop_front();
					{p0_x, p0_y, p0_z} <= {t.p[0], t.p[1], t.p[2]};
					{p1_x, p1_y, p1_z} <= {t.p[3], t.p[4], t.p[5]};
					{p2_x, p2_y, p2_z} <= {t.p[6], t.p[7], t.p[8]};
					{vert_a_index, vert_b_index, vert_c_index} <= {t.idx[0], t.idx[1], t.idx[2]};
					tri_valid <= 1'b1;
					tx_gap <= gap_len();
				end else begin
					tri_valid <= 1'b0;
				end
			end
			if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				rx_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			end
		end
	end

	function automatic tri_t current_tri();
		tri_t t;
		t.p = '{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z};
		t.idx = '{vert_a_index, vert_b_index, vert_c_index};
		return t;
	endfunction

	// monitor
	always @(posedge clk) begin
		face_t f, got;
		bit bad;
		tri_accepted <= tri_valid && !tri_stall;
		if (arst_n) begin
			if (tri_valid && !tri_stall)
				expected_faces.push_back(face_of(current_tri()));
			if (res_valid && !res_stall) begin
				got.nrm = '{normal_x, normal_y, normal_z};
				got.tng = '{tangent_x, tangent_y, tangent_z};
				got.idx = '{out_a_index, out_b_index, out_c_index};
				got.degen = degenerate;
				if (expected_faces.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction at %0t", $realtime);
				end else begin
					f = expected_faces.pop_front();
					bad = (f.degen !== got.degen);
					for (int i = 0; i < 3; i++)
						bad |= (f.nrm[i] !== got.nrm[i]) || (f.tng[i] !== got.tng[i]) ||
							(f.idx[i] !== got.idx[i]);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp n=%0d,%0d,%0d t=%0d,%0d,%0d i=%h,%h,%h d=%b",
								f.nrm[0], f.nrm[1], f.nrm[2], f.tng[0], f.tng[1], f.tng[2],
								f.idx[0], f.idx[1], f.idx[2], f.degen);
							$display("          got n=%0d,%0d,%0d t=%0d,%0d,%0d i=%h,%h,%h d=%b",
								got.nrm[0], got.nrm[1], got.nrm[2], got.tng[0], got.tng[1],
								got.tng[2], got.idx[0], got.idx[1], got.idx[2], got.degen);
						end
					end
				end
			end
			if ((tri_valid && !tri_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_stimulus();
		wait (expected_faces.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && expected_faces.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
